FILE: rtl/assert_macros.svh
// Assertion helpers included by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/bpq_pkg.sv
`timescale 1ns / 1ps
package bpq_pkg;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_EVICTED = 3'd1,
		ST_DROPPED = 3'd2,
		ST_SENT    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_SEND = 1'b1;

	localparam int FILL_BITS = 4;

endpackage

FILE: rtl/bpq_select.sv
`timescale 1ns / 1ps
// Compare tree over the slots: picks the valid slot with the highest
// (FIND_MAX = 1) or lowest priority, lowest index on ties.
module bpq_select #(
	parameter int DEPTH     = 8,
	parameter int PRIO_BITS = 8,
	parameter bit FIND_MAX  = 1'b1,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic [DEPTH-1:0]     valid,
	input  logic [PRIO_BITS-1:0] prio [DEPTH],
	output logic                 found,
	output logic [IW-1:0]        index,
	output logic [PRIO_BITS-1:0] best_prio
);

	localparam int LEAVES = 1 << IW;
	localparam int NODES  = 2 * LEAVES - 1;

	logic                 node_v [NODES];
	logic [PRIO_BITS-1:0] node_p [NODES];
	logic [IW-1:0]        node_i [NODES];

	genvar k;
	generate
		for (k = 0; k < LEAVES; k++) begin : g_leaf
			if (k < DEPTH) begin : g_real
				assign node_v[LEAVES-1+k] = valid[k];
				assign node_p[LEAVES-1+k] = prio[k];
			end else begin : g_pad
				assign node_v[LEAVES-1+k] = 1'b0;
				assign node_p[LEAVES-1+k] = '0;
			end
			assign node_i[LEAVES-1+k] = IW'(k);
		end

		for (k = 0; k < LEAVES - 1; k++) begin : g_node
			logic better;
			logic take_r;
			assign better = FIND_MAX ? (node_p[2*k+2] > node_p[2*k+1])
			                         : (node_p[2*k+2] < node_p[2*k+1]);
			// Left child holds the lower indexes: it wins unless the right is strictly better.
			assign take_r = node_v[2*k+2] && (!node_v[2*k+1] || better);
			assign node_v[k] = node_v[2*k+1] || node_v[2*k+2];
			assign node_p[k] = take_r ? node_p[2*k+2] : node_p[2*k+1];
			assign node_i[k] = take_r ? node_i[2*k+2] : node_i[2*k+1];
		end
	endgenerate

	assign found     = node_v[0];
	assign index     = node_i[0];
	assign best_prio = node_p[0];

endmodule

FILE: rtl/bounded_priority_queue_evict_lowest.sv
`timescale 1ns / 1ps
// Channel | Handshake          | Word
// in      | in_valid/in_ready   | req_type, msg_id, msg_priority
// out     | out_valid/out_ready | status, out_id, out_priority, fill_count
//
// One request per cycle sustained while the result register is not stalled.
// Each request passes an input register, then one pass of slot compare trees
// (free, lowest, highest) updates the slots and loads the result register.
// Reset clears all slot valid bits and the occupancy count; slot contents stay as is.
// A stalled result holds the pipeline; an empty input register still takes one word meanwhile.
`include "assert_macros.svh"
module bounded_priority_queue_evict_lowest import bpq_pkg::*; #(
	parameter int DEPTH     = 8,
	parameter int ID_BITS   = 16,
	parameter int PRIO_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic [ID_BITS-1:0]   msg_id,
	input  logic [PRIO_BITS-1:0] msg_priority,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [ID_BITS-1:0]   out_id,
	output logic [PRIO_BITS-1:0] out_priority,
	output logic [FILL_BITS-1:0] fill_count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// input register
	logic                 valid_s1;
	logic                 req_s1;
	logic [ID_BITS-1:0]   id_s1;
	logic [PRIO_BITS-1:0] prio_s1;

	// slot store
	logic [ID_BITS-1:0]   slot_id_q   [DEPTH];
	logic [PRIO_BITS-1:0] slot_prio_q [DEPTH];
	logic [DEPTH-1:0]     slot_valid_q;
	logic [CW-1:0]        occ_q;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [ID_BITS-1:0]   out_id_q;
	logic [PRIO_BITS-1:0] out_prio_q;
	logic [FILL_BITS-1:0] fill_q;

	logic                 advance;
	logic                 free_found, low_found, high_found;
	logic [IW-1:0]        free_idx, low_idx, high_idx;
	logic [PRIO_BITS-1:0] free_prio, low_prio, high_prio;
	logic [PRIO_BITS-1:0] zero_prio [DEPTH];

	logic                 wr_en, set_v, clr_v, hit;
	logic [IW-1:0]        wr_idx, rd_idx;
	status_t              st_d;
	logic [CW-1:0]        occ_d;
	logic [CW+FILL_BITS-1:0] occ_ext;
	logic [PRIO_BITS-1:0] hit_prio;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_type;
			id_s1   <= msg_id;
			prio_s1 <= msg_priority;
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			zero_prio[i] = '0;
		end
	end

	// equal priorities make this a first-free-slot search
	bpq_select #(.DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .FIND_MAX(1'b0)) u_free (
		.valid     (~slot_valid_q),
		.prio      (zero_prio),
		.found     (free_found),
		.index     (free_idx),
		.best_prio (free_prio)
	);

	bpq_select #(.DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .FIND_MAX(1'b0)) u_low (
		.valid     (slot_valid_q),
		.prio      (slot_prio_q),
		.found     (low_found),
		.index     (low_idx),
		.best_prio (low_prio)
	);

	bpq_select #(.DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .FIND_MAX(1'b1)) u_high (
		.valid     (slot_valid_q),
		.prio      (slot_prio_q),
		.found     (high_found),
		.index     (high_idx),
		.best_prio (high_prio)
	);

	always_comb begin
		wr_en    = 1'b0;
		set_v    = 1'b0;
		clr_v    = 1'b0;
		hit      = 1'b0;
		wr_idx   = free_idx;
		rd_idx   = high_idx;
		hit_prio = high_prio;
		st_d     = ST_DROPPED;
		occ_d    = occ_q;
		if (req_s1 == REQ_ADD) begin
			if (free_found) begin
				wr_en = 1'b1;
				set_v = 1'b1;
				st_d  = ST_ADDED;
				occ_d = occ_q + CW'(1);
			end else if (low_found && (low_prio < prio_s1)) begin
				// full: replace the weakest entry
				wr_en    = 1'b1;
				wr_idx   = low_idx;
				rd_idx   = low_idx;
				hit_prio = low_prio;
				hit      = 1'b1;
				st_d     = ST_EVICTED;
			end
		end else begin
			if (high_found) begin
				clr_v = 1'b1;
				hit   = 1'b1;
				st_d  = ST_SENT;
				occ_d = occ_q - CW'(1);
			end else begin
				st_d = ST_EMPTY;
			end
		end
	end

	assign occ_ext = {{FILL_BITS{1'b0}}, occ_d};

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			slot_id_q[wr_idx]   <= id_s1;
			slot_prio_q[wr_idx] <= prio_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			occ_q        <= '0;
		end else if (advance) begin
			if (set_v) begin
				slot_valid_q[wr_idx] <= 1'b1;
			end
			if (clr_v) begin
				slot_valid_q[rd_idx] <= 1'b0;
			end
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= st_d;
			out_id_q   <= hit ? slot_id_q[rd_idx] : '0;
			out_prio_q <= hit ? hit_prio : '0;
			fill_q     <= occ_ext[FILL_BITS-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_priority = out_prio_q;
	assign fill_count   = fill_q;

	`ASSERT_CLK(a_occ_matches, $countones(slot_valid_q) == occ_q, "occupancy differs from valid slots")
	`ASSERT_IMPL(a_evict_full, advance && req_s1 == REQ_ADD && !free_found, &slot_valid_q, "no free slot while not full")
	`ASSERT_IMPL(a_empty_zero, advance && req_s1 == REQ_SEND && !high_found, occ_q == '0, "empty report with entries held")
	`ASSERT_CLK(a_send_dec, advance && clr_v |=> occ_q == $past(occ_q) - CW'(1), "send did not drop occupancy")
	`ASSERT_IMPL(a_free_prio, free_found, free_prio == '0, "free search returned a nonzero key")

endmodule
